// File: design/bwsf_pkg.sv
// Shared types and constants of the box window sum filter.
// Holds the transaction structs, register and op codes, and widths.
// No dependencies; the core refers to it by scoped name.
`default_nettype none

package bwsf_pkg;

	localparam int MAX_WIDTH      = 1024;
	localparam int MAX_HEIGHT     = 1024;
	localparam int MAX_RADIUS     = 7;
	localparam int SAMPLE_BITS    = 16;
	localparam int COL_BITS       = 10;
	localparam int ROW_BITS       = 11;
	localparam int DIM_BITS       = 11;
	localparam int RAD_BITS       = 3;
	localparam int CS_BITS        = 20;
	localparam int SUM_BITS       = 24;
	localparam int OUT_POS_BITS   = 10;
	localparam int LINE_ROWS      = 2 * MAX_RADIUS;
	localparam int LROW_BITS      = 4;
	localparam int LINE_DEPTH     = LINE_ROWS * MAX_WIDTH;
	localparam int LINE_ADDR_BITS = LROW_BITS + COL_BITS;
	localparam int RING_MAX       = 2 * MAX_RADIUS + 1;
	localparam int TAP_BITS       = 4;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 11;

	localparam logic [RAD_BITS-1:0] RADIUS_RESET = 3'd3;
	localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 11'd480;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_RADIUS       = 2'd0,
		CFG_FRAME_WIDTH  = 2'd1,
		CFG_FRAME_HEIGHT = 2'd2
	} cfg_index_t;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_FLUSH  = 1'b1
	} op_t;

	typedef struct packed {
		op_t                    op;
		logic [SAMPLE_BITS-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [SUM_BITS-1:0]     window_sum;
		logic [OUT_POS_BITS-1:0] out_row;
		logic [OUT_POS_BITS-1:0] out_col;
		logic                    run_last;
		logic                    frame_last;
	} out_item_t;

endpackage

`default_nettype wire

// File: design/box_window_sum_filter_core.sv
// Box window sum filter core: streaming unnormalized square window sums.
// Depends on bwsf_pkg (types, constants) and bwsf_ram (column and line stores).
//
// Usage:
//  - src channel (src_valid/src_stall/src_item) takes one transaction per pixel
//    in raster order; op = OP_FLUSH feeds a zero sample. After frame_height rows
//    the stream must go on for radius drain rows (flush transactions) to release
//    the bottom rows; the position then wraps to a new frame.
//  - res channel (res_valid/res_stall/res_item) gives one transaction per output
//    pixel, run_last marking the last one caused by an input transaction and
//    frame_last the bottom right pixel of the frame.
//  - cfg port writes radius, frame_width, frame_height; any write restarts the
//    frame. Write only while the core is idle.
// Path: an accepted input goes through stage 1, stage 2 and the result register.
// Throughput: one input per cycle inside a row unless src_stall is raised. The last
//   input of a row releases min(radius+1, width) results through the single result
//   register, and stage 2 holds the next input until the last of them has left.
// Reset: clears position, pipeline and config (radius 3, 640 x 480). No clearing
//   pass: column sums read as zero on the first row of each frame.
// Stall: res_stall holds the result register; back pressure reaches src_stall
//   in the same cycle once the pipeline stages are full.
`default_nettype none

module box_window_sum_filter_core (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 src_valid,
	output logic                                      src_stall,
	input  wire bwsf_pkg::in_item_t                   src_item,
	output logic                                      res_valid,
	input  wire logic                                 res_stall,
	output bwsf_pkg::out_item_t                       res_item,
	input  wire logic                                 cfg_we,
	input  wire logic [bwsf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [bwsf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	// ---------------- configuration ----------------
	logic [bwsf_pkg::RAD_BITS-1:0] radius_q;
	logic [bwsf_pkg::DIM_BITS-1:0] width_q;
	logic [bwsf_pkg::DIM_BITS-1:0] height_q;
	logic                          cfg_restart;

	always_comb begin
		cfg_restart = 1'b0;
		if (cfg_we) begin
			case (cfg_index)
				bwsf_pkg::CFG_RADIUS:       cfg_restart = 1'b1;
				bwsf_pkg::CFG_FRAME_WIDTH:  cfg_restart = 1'b1;
				bwsf_pkg::CFG_FRAME_HEIGHT: cfg_restart = 1'b1;
				default:                    cfg_restart = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= bwsf_pkg::RADIUS_RESET;
			width_q  <= bwsf_pkg::WIDTH_RESET;
			height_q <= bwsf_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bwsf_pkg::CFG_RADIUS:       radius_q <= cfg_data[bwsf_pkg::RAD_BITS-1:0];
				bwsf_pkg::CFG_FRAME_WIDTH:  width_q  <= cfg_data;
				bwsf_pkg::CFG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the registers to their working range.
	logic [bwsf_pkg::RAD_BITS-1:0]  r_eff;
	logic [bwsf_pkg::DIM_BITS-1:0]  w_eff;
	logic [bwsf_pkg::DIM_BITS-1:0]  h_eff;
	logic [bwsf_pkg::TAP_BITS-1:0]  two_r;
	logic [bwsf_pkg::TAP_BITS-1:0]  r4;

	always_comb begin
		r_eff = (radius_q == '0) ? bwsf_pkg::RAD_BITS'(1) : radius_q;
		if (width_q == '0) begin
			w_eff = bwsf_pkg::DIM_BITS'(1);
		end else if (width_q > bwsf_pkg::DIM_BITS'(bwsf_pkg::MAX_WIDTH)) begin
			w_eff = bwsf_pkg::DIM_BITS'(bwsf_pkg::MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = bwsf_pkg::DIM_BITS'(1);
		end else if (height_q > bwsf_pkg::DIM_BITS'(bwsf_pkg::MAX_HEIGHT)) begin
			h_eff = bwsf_pkg::DIM_BITS'(bwsf_pkg::MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
		two_r = {r_eff, 1'b0};
		r4    = {1'b0, r_eff};
	end

	// ---------------- stage 0: accept, position, memory reads ----------------
	logic                                  accept;
	logic                                  s1_adv;
	logic                                  s2_ready;
	logic                                  valid_s1;
	logic [bwsf_pkg::COL_BITS-1:0]         col_q;
	logic [bwsf_pkg::ROW_BITS-1:0]         row_q;
	logic [bwsf_pkg::LROW_BITS-1:0]        lrow_q;
	logic [bwsf_pkg::SAMPLE_BITS-1:0]      sample_v;
	logic [bwsf_pkg::COL_BITS:0]           col_inc;
	logic [bwsf_pkg::ROW_BITS:0]           row_inc;
	logic [bwsf_pkg::LROW_BITS-1:0]        lrow_inc;
	logic                                  row_end;
	logic                                  frame_end;
	logic [bwsf_pkg::LINE_ADDR_BITS-1:0]   line_raddr;

	assign src_stall = valid_s1 && !s2_ready;
	assign accept    = src_valid && !src_stall;
	assign s1_adv    = valid_s1 && s2_ready;

	always_comb begin
		// Drain rows and flush transactions feed zeros.
		sample_v = ((src_item.op == bwsf_pkg::OP_SAMPLE) && (row_q < h_eff))
			? src_item.sample : '0;
		col_inc   = {1'b0, col_q} + (bwsf_pkg::COL_BITS + 1)'(1);
		row_end   = col_inc >= w_eff;
		row_inc   = {1'b0, row_q} + (bwsf_pkg::ROW_BITS + 1)'(1);
		frame_end = row_inc >= ({1'b0, h_eff} + (bwsf_pkg::ROW_BITS + 1)'(r_eff));
		lrow_inc  = lrow_q + bwsf_pkg::LROW_BITS'(1);
		line_raddr = {lrow_q, col_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			lrow_q <= '0;
		end else if (cfg_restart) begin
			col_q  <= '0;
			row_q  <= '0;
			lrow_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				if (frame_end) begin
					row_q  <= '0;
					lrow_q <= '0;
				end else begin
					row_q  <= row_inc[bwsf_pkg::ROW_BITS-1:0];
					lrow_q <= (lrow_inc == two_r) ? '0 : lrow_inc;
				end
			end else begin
				col_q <= col_inc[bwsf_pkg::COL_BITS-1:0];
			end
		end
	end

	// ---------------- stage 1: read-modify-write of the stores ----------------
	logic [bwsf_pkg::SAMPLE_BITS-1:0]    v_s1;
	logic [bwsf_pkg::COL_BITS-1:0]       col_s1;
	logic [bwsf_pkg::ROW_BITS-1:0]       row_s1;
	logic [bwsf_pkg::LINE_ADDR_BITS-1:0] laddr_s1;
	logic                                old_en_s1;
	logic                                zero_col_s1;
	logic                                last_s1;
	logic                                fwd_s1;
	logic [bwsf_pkg::CS_BITS-1:0]        fwd_val_s1;
	logic [bwsf_pkg::CS_BITS-1:0]        col_rdata;
	logic [bwsf_pkg::SAMPLE_BITS-1:0]    line_rdata;
	logic [bwsf_pkg::CS_BITS-1:0]        col_base;
	logic [bwsf_pkg::SAMPLE_BITS-1:0]    old_v;
	logic [bwsf_pkg::CS_BITS-1:0]        cs_s1;
	logic [bwsf_pkg::CS_BITS-1:0]        newcol;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			v_s1        <= sample_v;
			col_s1      <= col_q;
			row_s1      <= row_q;
			laddr_s1    <= line_raddr;
			old_en_s1   <= row_q >= bwsf_pkg::ROW_BITS'(two_r);
			// First row of a frame: column sums start from zero.
			zero_col_s1 <= row_q == '0;
			last_s1     <= row_end;
			// Catch a column write landing in the same cycle as this read.
			fwd_s1      <= s1_adv && (col_s1 == col_q);
			fwd_val_s1  <= newcol;
		end
	end

	always_comb begin
		if (zero_col_s1) begin
			col_base = '0;
		end else if (fwd_s1) begin
			col_base = fwd_val_s1;
		end else begin
			col_base = col_rdata;
		end
		old_v  = old_en_s1 ? line_rdata : '0;
		cs_s1  = col_base + bwsf_pkg::CS_BITS'(v_s1);
		newcol = cs_s1 - bwsf_pkg::CS_BITS'(old_v);
	end

	bwsf_ram #(
		.DEPTH (bwsf_pkg::MAX_WIDTH),
		.WIDTH (bwsf_pkg::CS_BITS)
	) u_col_ram (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (col_s1),
		.wdata (newcol),
		.re    (accept),
		.raddr (col_q),
		.rdata (col_rdata)
	);

	bwsf_ram #(
		.DEPTH (bwsf_pkg::LINE_DEPTH),
		.WIDTH (bwsf_pkg::SAMPLE_BITS)
	) u_line_ram (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (laddr_s1),
		.wdata (v_s1),
		.re    (accept),
		.raddr (line_raddr),
		.rdata (line_rdata)
	);

	// ---------------- stage 2: horizontal sum and result release ----------------
	logic                              valid_s2;
	logic                              tail_q;
	logic [bwsf_pkg::CS_BITS-1:0]      cs_s2;
	logic [bwsf_pkg::COL_BITS-1:0]     x_s2;
	logic [bwsf_pkg::ROW_BITS-1:0]     y_s2;
	logic                              last_s2;
	logic [bwsf_pkg::COL_BITS-1:0]     c_q;
	logic [bwsf_pkg::SUM_BITS-1:0]     s_q;
	logic [bwsf_pkg::SUM_BITS-1:0]     hsum_q;
	logic [bwsf_pkg::CS_BITS-1:0]      taps_q [bwsf_pkg::RING_MAX];

	logic                              out_free;
	logic                              emit0;
	logic                              emit;
	logic                              go_tail;
	logic                              p0_fire;
	logic                              tail_fire;
	logic                              s2_done;
	logic [bwsf_pkg::COL_BITS-1:0]     lo;
	logic [bwsf_pkg::COL_BITS-1:0]     c_next;
	logic [bwsf_pkg::COL_BITS-1:0]     col_gap;
	logic [bwsf_pkg::TAP_BITS-1:0]     sel_idx;
	logic [bwsf_pkg::CS_BITS-1:0]      tap_sel;
	logic [bwsf_pkg::CS_BITS-1:0]      sub0;
	logic [bwsf_pkg::CS_BITS-1:0]      sub_t;
	logic [bwsf_pkg::SUM_BITS-1:0]     hsum_base;
	logic [bwsf_pkg::SUM_BITS-1:0]     hsum_new;
	logic [bwsf_pkg::SUM_BITS-1:0]     s_next;
	logic [bwsf_pkg::ROW_BITS-1:0]     orow_full;
	logic                              orow_last;
	bwsf_pkg::out_item_t               emit_item;

	assign out_free = !res_valid || !res_stall;

	always_comb begin
		lo        = (x_s2 >= bwsf_pkg::COL_BITS'(r_eff)) ? x_s2 - bwsf_pkg::COL_BITS'(r_eff) : '0;
		orow_full = y_s2 - bwsf_pkg::ROW_BITS'(r_eff);
		orow_last = orow_full == (h_eff - bwsf_pkg::DIM_BITS'(1));
		emit0     = (y_s2 >= bwsf_pkg::ROW_BITS'(r_eff))
			&& (last_s2 || (x_s2 >= bwsf_pkg::COL_BITS'(r_eff)));
		go_tail   = last_s2 && emit0 && (x_s2 != lo);
		c_next    = c_q + bwsf_pkg::COL_BITS'(1);
		col_gap   = x_s2 - c_next;

		// One tap port: the column leaving the window on entry, or the one
		// dropped at each step of the right-edge run.
		sel_idx = tail_q ? (col_gap[bwsf_pkg::TAP_BITS-1:0] + r4 + bwsf_pkg::TAP_BITS'(1))
			: two_r;
		tap_sel = taps_q[sel_idx];

		sub0      = (x_s2 > bwsf_pkg::COL_BITS'(two_r)) ? tap_sel : '0;
		hsum_base = (x_s2 == '0) ? '0 : hsum_q;
		hsum_new  = hsum_base + bwsf_pkg::SUM_BITS'(cs_s2) - bwsf_pkg::SUM_BITS'(sub0);
		sub_t     = (c_next > bwsf_pkg::COL_BITS'(r_eff)) ? tap_sel : '0;
		s_next    = s_q - bwsf_pkg::SUM_BITS'(sub_t);

		emit      = valid_s2 && (tail_q || emit0);
		p0_fire   = valid_s2 && !tail_q && (!emit0 || out_free);
		tail_fire = tail_q && out_free;
		s2_done   = (p0_fire && !go_tail) || (tail_fire && (c_next == x_s2));
		s2_ready  = !valid_s2 || s2_done;

		emit_item.out_row = orow_full[bwsf_pkg::OUT_POS_BITS-1:0];
		if (tail_q) begin
			emit_item.window_sum = s_next;
			emit_item.out_col    = c_next;
			emit_item.run_last   = c_next == x_s2;
			emit_item.frame_last = (c_next == x_s2) && orow_last;
		end else begin
			emit_item.window_sum = hsum_new;
			emit_item.out_col    = lo;
			emit_item.run_last   = !go_tail;
			emit_item.frame_last = last_s2 && !go_tail && orow_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			tail_q   <= 1'b0;
		end else begin
			if (s1_adv) begin
				valid_s2 <= 1'b1;
			end else if (s2_done) begin
				valid_s2 <= 1'b0;
			end
			if (p0_fire && go_tail) begin
				tail_q <= 1'b1;
			end else if (tail_fire && (c_next == x_s2)) begin
				tail_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			cs_s2   <= cs_s1;
			x_s2    <= col_s1;
			y_s2    <= row_s1;
			last_s2 <= last_s1;
		end
		if (p0_fire) begin
			hsum_q    <= hsum_new;
			c_q       <= lo;
			s_q       <= hsum_new;
			taps_q[0] <= cs_s2;
			for (int i = 1; i < bwsf_pkg::RING_MAX; i++) begin
				taps_q[i] <= taps_q[i-1];
			end
		end else if (tail_fire) begin
			c_q <= c_next;
			s_q <= s_next;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (out_free) begin
			res_valid <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit) begin
			res_item <= emit_item;
		end
	end

`ifndef SYNTHESIS
	a_tail_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q |-> valid_s2)
		else $error("right-edge run active without an item in stage 2");

	a_tail_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q |-> (c_q < x_s2))
		else $error("right-edge run passed the last column");

	a_lrow_range: assert property (@(posedge clk) disable iff (!arst_n)
		lrow_q < two_r)
		else $error("line store row pointer out of range");

	a_fwd_single_col: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && fwd_s1 && !zero_col_s1) |-> (w_eff == bwsf_pkg::DIM_BITS'(1)))
		else $error("column forward taken with adjacent transactions in distinct columns");
`endif

endmodule

`default_nettype wire

// File: design/bwsf_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Read-first on a same-address collision. No package dependency.
`default_nettype none

module bwsf_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
